[design/mdb_pkg.sv]
// Shared widths and constants for the modulated delay DC blocker.
package mdb_pkg;

	localparam int SMP_W   = 16;
	localparam int BASE_W  = 24;
	localparam int MOD_W   = 16;
	localparam int POLE_W  = 15;
	localparam int SUM_W   = 26;
	localparam int FRAC_W  = 8;
	localparam int WHOLE_W = 17;

	localparam logic [POLE_W-1:0] POLE_RST = 15'd32604;

	typedef logic signed [SMP_W-1:0] smp_t;

endpackage

[design/mdb_if.sv]
// Channel interfaces: sample feed, filtered result and pole register write.
interface mdb_feed_if;
	logic                        valid;
	logic                        ready;
	logic signed [15:0]          in_sample;
	logic [mdb_pkg::BASE_W-1:0]  delay_base;
	logic signed [15:0]          delay_mod;

	modport source (output valid, in_sample, delay_base, delay_mod, input ready);
	modport sink (input valid, in_sample, delay_base, delay_mod, output ready);
endinterface

interface mdb_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] out_sample;

	modport source (output valid, out_sample, input ready);
	modport sink (input valid, out_sample, output ready);
endinterface

interface mdb_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [mdb_pkg::POLE_W-1:0]  dc_pole;

	modport source (output valid, dc_pole, input ready);
	modport sink (input valid, dc_pole, output ready);
endinterface

[design/mdb_addr.sv]
// Delay address pipeline: whole delay, reduction modulo DEPTH, read offset.
module mdb_addr #(
	parameter int DEPTH = 65536
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       up_valid,
	output logic                       up_ready,
	input  mdb_pkg::smp_t              up_smp,
	input  logic [mdb_pkg::BASE_W-1:0] up_base,
	input  logic signed [mdb_pkg::MOD_W-1:0] up_mod,
	output logic                       dn_valid,
	input  logic                       dn_ready,
	output mdb_pkg::smp_t              dn_smp,
	output logic [$clog2(DEPTH)-1:0]   dn_dm
);

	localparam int AW   = $clog2(DEPTH);
	localparam int WN   = mdb_pkg::WHOLE_W;
	localparam int KSH  = WN + AW;
	localparam int RW   = WN + 1;
	localparam int PW   = WN + RW;
	localparam int QW   = WN + AW + 1;
	localparam longint unsigned RECIP = (64'd1 << KSH) / 64'(DEPTH);
	localparam logic [AW:0] DEP1 = (AW + 1)'(DEPTH);

	logic live_q;
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	logic [WN-1:0] whole_s1, whole_s2;
	logic          neg_s1, neg_s2, neg_s3;
	mdb_pkg::smp_t smp_s1, smp_s2, smp_s3, smp_s4;
	logic [WN-1:0] q_s2;
	logic [AW:0]   rr_s3;
	logic [AW-1:0] dm_s4;

	logic signed [mdb_pkg::SUM_W-1:0] sum;
	logic [mdb_pkg::SUM_W-1:0]        mag;
	logic [PW-1:0] qprod, qsh;
	logic [QW-1:0] qd, diff;
	logic [AW:0]   rfix, dmw;

	assign en4 = !v_s4 || dn_ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign up_ready = en1 && live_q;

	// summed delay, magnitude truncated toward zero
	assign sum = $signed({2'b00, up_base})
		+ {{(mdb_pkg::SUM_W - mdb_pkg::MOD_W){up_mod[mdb_pkg::MOD_W-1]}}, up_mod};
	assign mag = sum[mdb_pkg::SUM_W-1] ? mdb_pkg::SUM_W'(-sum) : mdb_pkg::SUM_W'(sum);

	// quotient by reciprocal, may fall one short
	assign qprod = PW'(whole_s1) * PW'(RECIP);
	assign qsh   = qprod >> KSH;

	assign qd   = QW'(q_s2) * QW'(DEPTH);
	assign diff = QW'(whole_s2) - qd;

	assign rfix = (rr_s3 >= DEP1) ? rr_s3 - DEP1 : rr_s3;
	assign dmw  = (neg_s3 && rfix != '0) ? DEP1 - rfix : rfix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
		end else begin
			live_q <= 1'b1;
			if (en1) v_s1 <= up_valid && up_ready;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			whole_s1 <= mag[mdb_pkg::FRAC_W +: WN];
			neg_s1   <= sum[mdb_pkg::SUM_W-1];
			smp_s1   <= up_smp;
		end
		if (en2) begin
			whole_s2 <= whole_s1;
			neg_s2   <= neg_s1;
			smp_s2   <= smp_s1;
			q_s2     <= qsh[WN-1:0];
		end
		if (en3) begin
			neg_s3 <= neg_s2;
			smp_s3 <= smp_s2;
			rr_s3  <= diff[AW:0];
		end
		if (en4) begin
			smp_s4 <= smp_s3;
			dm_s4  <= dmw[AW-1:0];
		end
	end

	assign dn_valid = v_s4;
	assign dn_smp   = smp_s4;
	assign dn_dm    = dm_s4;

endmodule

[design/mdb_store.sv]
// Delay store: write pointer, sample RAM, fill tracking and same-entry bypass.
module mdb_store #(
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     up_valid,
	output logic                     up_ready,
	input  mdb_pkg::smp_t            up_smp,
	input  logic [$clog2(DEPTH)-1:0] up_dm,
	output logic                     dn_valid,
	input  logic                     dn_ready,
	output mdb_pkg::smp_t            dn_x
);

	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [AW:0]   DEP1 = (AW + 1)'(DEPTH);

	logic [mdb_pkg::SMP_W-1:0] mem [DEPTH];

	logic [AW-1:0] wp_q;
	logic          full_q;
	logic          v_s5;
	logic [mdb_pkg::SMP_W-1:0] rdat_s5;
	mdb_pkg::smp_t smp_s5;
	logic          byp_s5, ok_s5;

	logic          go;
	logic [AW-1:0] wpn, rd;
	logic [AW:0]   wrap;

	assign up_ready = !v_s5 || dn_ready;
	assign go       = up_valid && up_ready;

	assign wpn  = (wp_q == LAST) ? '0 : wp_q + 1'b1;
	assign wrap = {1'b0, wpn} + DEP1 - {1'b0, up_dm};
	assign rd   = (wpn >= up_dm) ? wpn - up_dm : wrap[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			full_q <= 1'b0;
			v_s5   <= 1'b0;
		end else begin
			if (up_ready) v_s5 <= up_valid;
			if (go) begin
				wp_q <= wpn;
				if (wpn == '0) full_q <= 1'b1;
			end
		end
	end

	// entries never written since reset read as zero
	always_ff @(posedge clk) begin
		if (go) begin
			mem[wpn] <= up_smp;
			rdat_s5  <= mem[rd];
			smp_s5   <= up_smp;
			byp_s5   <= (rd == wpn);
			ok_s5    <= full_q || (wpn == '0) || (rd != '0 && rd <= wpn);
		end
	end

	assign dn_valid = v_s5;
	assign dn_x     = byp_s5 ? smp_s5 : (ok_s5 ? $signed(rdat_s5) : '0);

endmodule

[design/mdb_dcblk.sv]
// DC blocker with pole register, saturation and output register.
module mdb_dcblk (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       up_valid,
	output logic                       up_ready,
	input  mdb_pkg::smp_t              up_x,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [mdb_pkg::POLE_W-1:0] cfg_pole,
	output logic                       dn_valid,
	input  logic                       dn_ready,
	output mdb_pkg::smp_t              dn_y
);

	logic                       live_q;
	logic [mdb_pkg::POLE_W-1:0] pole_q;
	mdb_pkg::smp_t              xp_q, yp_q, out_q;
	logic                       out_v_q;

	logic signed [31:0] prod, ps;
	logic signed [16:0] term;
	logic signed [18:0] y;
	mdb_pkg::smp_t      ysat;
	logic               go;

	assign up_ready  = !out_v_q || dn_ready;
	assign go        = up_valid && up_ready;
	assign cfg_ready = live_q;

	// pole * y_prev, rounded half up at bit 15
	assign prod = $signed({1'b0, pole_q}) * yp_q;
	assign ps   = prod + 32'sd16384;
	assign term = ps[31:15];
	assign y    = {{3{up_x[15]}}, up_x} - {{3{xp_q[15]}}, xp_q} + {{2{term[16]}}, term};

	always_comb begin
		if (y > 19'sd32767) ysat = 16'sh7FFF;
		else if (y < -19'sd32768) ysat = 16'sh8000;
		else ysat = y[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q  <= 1'b0;
			pole_q  <= mdb_pkg::POLE_RST;
			xp_q    <= '0;
			yp_q    <= '0;
			out_v_q <= 1'b0;
		end else begin
			live_q <= 1'b1;
			if (cfg_valid && cfg_ready) pole_q <= cfg_pole;
			if (up_ready) out_v_q <= up_valid;
			if (go) begin
				xp_q <= up_x;
				yp_q <= ysat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) out_q <= ysat;
	end

	assign dn_valid = out_v_q;
	assign dn_y     = out_q;

endmodule

[design/modulated_delay_dc_block.sv]
// Top level: modulated delay line feeding a DC blocker.
//
// Channels: feed takes one item per handshake (in_sample Q1.15, delay_base
// and delay_mod in samples with 8 fraction bits); result gives one
// out_sample per item, in order; cfg writes the 15-bit dc_pole register
// and should only be used while no item is in flight.
// Pipeline: six register stages lie between an accepted item and its
// result, the last of them being the output register.
// Throughput: one item per cycle while result is taken, set by the DC
// blocker feedback (one multiply-add per cycle) and the single write plus
// single read port of the delay RAM.
// Reset: the write pointer and filter history clear and the pole returns
// to 32604. The delay RAM is not swept; a fill mark makes entries not yet
// written since reset read as zero. feed goes ready on the edge after reset.
// Stall: when result is not taken the output register holds; the five
// internal stages keep filling and feed drops ready once all six hold items.
module modulated_delay_dc_block #(
	parameter int DEPTH = 65536
) (
	input  logic          clk,
	input  logic          arst_n,
	mdb_feed_if.sink      feed,
	mdb_result_if.source  result,
	mdb_cfg_if.sink       cfg
);

	localparam int AW = $clog2(DEPTH);

	logic          a_valid, a_ready;
	mdb_pkg::smp_t a_smp;
	logic [AW-1:0] a_dm;
	logic          s_valid, s_ready;
	mdb_pkg::smp_t s_x;

	mdb_addr #(.DEPTH(DEPTH)) u_addr (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (feed.valid),
		.up_ready (feed.ready),
		.up_smp   (feed.in_sample),
		.up_base  (feed.delay_base),
		.up_mod   (feed.delay_mod),
		.dn_valid (a_valid),
		.dn_ready (a_ready),
		.dn_smp   (a_smp),
		.dn_dm    (a_dm)
	);

	mdb_store #(.DEPTH(DEPTH)) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (a_valid),
		.up_ready (a_ready),
		.up_smp   (a_smp),
		.up_dm    (a_dm),
		.dn_valid (s_valid),
		.dn_ready (s_ready),
		.dn_x     (s_x)
	);

	mdb_dcblk u_dcblk (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (s_valid),
		.up_ready  (s_ready),
		.up_x      (s_x),
		.cfg_valid (cfg.valid),
		.cfg_ready (cfg.ready),
		.cfg_pole  (cfg.dc_pole),
		.dn_valid  (result.valid),
		.dn_ready  (result.ready),
		.dn_y      (result.out_sample)
	);

endmodule

[design/mdb_checker.sv]
// Port-level checks for the modulated delay DC blocker, bound to the top.
module mdb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] out_sample
);

	logic [3:0] cnt_q;
	logic       in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else if (in_acc && !out_acc) cnt_q <= cnt_q + 1'b1;
		else if (out_acc && !in_acc) cnt_q <= cnt_q - 1'b1;
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_sample))
		else $error("stalled result changed");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != 4'd0)
		else $error("result without a pending item");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 4'd6)
		else $error("more items in flight than pipeline stages");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) && !in_ready |-> out_valid && !out_ready)
		else $error("feed stalled while result side is free");

endmodule

bind modulated_delay_dc_block mdb_checker u_mdb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (feed.valid),
	.in_ready   (feed.ready),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.out_sample (result.out_sample)
);

[bench/modulated_delay_dc_block_tb.sv]
// Testbench for modulated_delay_dc_block: random and directed samples checked against a predictor.
module modulated_delay_dc_block_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT  = 2000;
	localparam int PHASE_ITEMS = 200;
	localparam int LONG_HOLD   = 80;

	logic clk;
	logic arst_n;

	mdb_feed_if   feed_ch();
	mdb_result_if result_ch();
	mdb_cfg_if    cfg_ch();

	modulated_delay_dc_block dut (
		.clk   (clk),
		.arst_n(arst_n),
		.feed  (feed_ch),
		.result(result_ch),
		.cfg   (cfg_ch)
	);

	// predictor state
	logic [mdb_pkg::SMP_W-1:0]  delay_mem [0:65535];
	logic [15:0]                wr_ptr;
	mdb_pkg::smp_t              x_prev;
	mdb_pkg::smp_t              y_prev;
	logic [mdb_pkg::POLE_W-1:0] pole_reg;
	mdb_pkg::smp_t              expected_out[$];

	int mismatch_count;
	int idle_cycles;
	int rx_gap;
	int rx_hold;
	bit rx_burst;
	bit tx_burst;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void predict_delay_filter(input mdb_pkg::smp_t smp,
			input logic [mdb_pkg::BASE_W-1:0] base,
			input logic signed [mdb_pkg::MOD_W-1:0] dmod);
		logic signed [mdb_pkg::SUM_W-1:0] dsum;
		logic [mdb_pkg::SUM_W-1:0]        mag;
		logic [15:0]                      rd;
		longint                           prod;
		longint                           acc;
		mdb_pkg::smp_t                    x;
		wr_ptr = wr_ptr + 16'd1;
		delay_mem[wr_ptr] = smp;
		dsum = $signed({2'b00, base}) + dmod;
		// delay truncates toward zero; negative delay reads ahead
		if (dsum < 0) begin
			mag = -dsum;
			rd = wr_ptr + mag[mdb_pkg::FRAC_W +: 16];
		end else begin
			mag = dsum;
			rd = wr_ptr - mag[mdb_pkg::FRAC_W +: 16];
		end
		x = delay_mem[rd];
		prod = longint'(pole_reg) * longint'(y_prev);
		acc = longint'(x) - longint'(x_prev) + ((prod + 64'sd16384) >>> 15);
		x_prev = x;
		if (acc > 32767) begin
			y_prev = 16'sh7FFF;
		end else if (acc < -32768) begin
			y_prev = 16'sh8000;
		end else begin
			y_prev = acc[15:0];
		end
		expected_out.push_back(y_prev);
	endfunction

	task automatic send_sample(input mdb_pkg::smp_t smp,
			input logic [mdb_pkg::BASE_W-1:0] base,
			input logic signed [mdb_pkg::MOD_W-1:0] dmod);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 11);
		repeat (gap) begin
			@(negedge clk);
			feed_ch.valid <= 1'b0;
		end
		@(negedge clk);
		feed_ch.valid      <= 1'b1;
		feed_ch.in_sample  <= smp;
		feed_ch.delay_base <= base;
		feed_ch.delay_mod  <= dmod;
		do @(posedge clk); while (!feed_ch.ready);
		predict_delay_filter(smp, base, dmod);
	endtask

	task automatic wait_results_drained();
		@(negedge clk);
		feed_ch.valid <= 1'b0;
		while (expected_out.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_pole(input logic [mdb_pkg::POLE_W-1:0] p);
		@(negedge clk);
		cfg_ch.valid   <= 1'b1;
		cfg_ch.dc_pole <= p;
		do @(posedge clk); while (!cfg_ch.ready);
		pole_reg = p;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic send_random_sample();
		mdb_pkg::smp_t                    smp;
		logic [mdb_pkg::BASE_W-1:0]       base;
		logic signed [mdb_pkg::MOD_W-1:0] dmod;
		int                               kind;
		kind = $urandom_range(0, 9);
		case ($urandom_range(0, 7))
			0: smp = 16'sh7FFF;
			1: smp = 16'sh8000;
			default: smp = 16'($urandom);
		endcase
		if (kind <= 4) begin
			base = 24'($urandom_range(0, 64 * 256));
			dmod = 16'($urandom_range(0, 4095) - 2048);
		end else if (kind == 5) begin
			base = 24'($urandom_range(0, 255));
			dmod = '0;
		end else if (kind == 6) begin
			base = 24'($urandom_range(0, 1023));
			dmod = 16'(-int'($urandom_range(0, 32768)));
		end else begin
			base = 24'($urandom);
			dmod = 16'($urandom);
		end
		send_sample(smp, base, dmod);
	endtask

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 64 == 0) begin
				tx_burst = ($urandom_range(0, 3) == 0);
				rx_burst = ($urandom_range(0, 3) == 0);
			end
			send_random_sample();
		end
		tx_burst = 1'b0;
		rx_burst = 1'b0;
	endtask

	// full-scale swings with zero and unit delay drive the output into saturation
	task automatic send_saturating_burst();
		for (int i = 0; i < 8; i++) begin
			send_sample(i[0] ? 16'sh8000 : 16'sh7FFF, (i < 4) ? 24'h0 : 24'h100, '0);
		end
	endtask

	task automatic test_delay_edges();
		send_sample(16'sh7FFF, 24'h000000, 16'sh0000);
		send_sample(16'sh8000, 24'h000000, 16'sh0000);
		send_sample(16'sh0000, 24'h0001FF, 16'sh0000);
		send_sample(-16'sd1,   24'hFFFFFF, 16'sh0000);
		send_sample(16'sh1234, 24'hFFFFFF, 16'sh7FFF);
		send_sample(16'sh5A5A, 24'h000000, 16'sh8000);
		send_sample(-16'sh5A5B, 24'h000080, -16'sh01FF);
		send_sample(16'sh0001, 24'h000200, 16'sh7FFF);
		send_sample(16'sh7FFF, 24'h000100, -16'sh0100);
		send_sample(16'sh2222, 24'h000300, 16'sh0000);
		send_sample(-16'sh3333, 24'h000000, -16'sh0001);
		send_saturating_burst();
		wait_results_drained();
	endtask

	task automatic test_pole_settings();
		logic [mdb_pkg::POLE_W-1:0] poles [6];
		poles = '{15'd32767, 15'd0, 15'd1, 15'd16384, 15'($urandom), mdb_pkg::POLE_RST};
		foreach (poles[k]) begin
			write_pole(poles[k]);
			send_saturating_burst();
			run_random(PHASE_ITEMS);
			wait_results_drained();
		end
	endtask

	task automatic test_backpressure();
		tx_burst = 1'b1;
		rx_hold  = LONG_HOLD;
		for (int i = 0; i < 60; i++) begin
			send_random_sample();
		end
		tx_burst = 1'b0;
		wait_results_drained();
		run_random(40);
		wait_results_drained();
	endtask

	// result side: random per-item gaps, bursts, and one long hold-off
	initial begin
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				result_ch.ready <= 1'b0;
				rx_hold--;
			end else if (rx_gap > 0) begin
				result_ch.ready <= 1'b0;
				rx_gap--;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		mdb_pkg::smp_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_out.size() == 0) begin
				$display("%0t: unexpected item, expected none, got out_sample %0d",
					$time, result_ch.out_sample);
				mismatch_count++;
			end else begin
				want = expected_out.pop_front();
				if (result_ch.out_sample !== want) begin
					$display("%0t: out_sample expected %0d, got %0d",
						$time, want, result_ch.out_sample);
					mismatch_count++;
				end
			end
			rx_gap = rx_burst ? 0 : $urandom_range(0, 11);
		end
	end

	always @(posedge clk) begin
		if ((feed_ch.valid && feed_ch.ready) || (result_ch.valid && result_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready) || !arst_n) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("modulated_delay_dc_block: mismatch");
				$finish;
			end
		end
	end

	initial begin
		arst_n             = 1'b0;
		feed_ch.valid      = 1'b0;
		feed_ch.in_sample  = '0;
		feed_ch.delay_base = '0;
		feed_ch.delay_mod  = '0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.dc_pole     = '0;
		mismatch_count     = 0;
		idle_cycles        = 0;
		rx_gap             = 0;
		rx_hold            = 0;
		rx_burst           = 1'b0;
		tx_burst           = 1'b0;
		wr_ptr             = '0;
		x_prev             = '0;
		y_prev             = '0;
		pole_reg           = mdb_pkg::POLE_RST;
		foreach (delay_mem[i]) delay_mem[i] = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_delay_edges();
		test_backpressure();
		test_pole_settings();

		wait_results_drained();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && expected_out.size() == 0) begin
			$display("modulated_delay_dc_block: match");
		end else begin
			$display("modulated_delay_dc_block: mismatch");
		end
		$finish;
	end

endmodule

[modulated_delay_dc_block.f]
design/mdb_pkg.sv
design/mdb_if.sv
design/mdb_addr.sv
design/mdb_store.sv
design/mdb_dcblk.sv
design/modulated_delay_dc_block.sv
design/mdb_checker.sv
bench/modulated_delay_dc_block_tb.sv
